// ===== hw/rtl/lsq_pkg.sv =====
// shared constants, codes and request/result types of the linked slot queue engine
package lsq_pkg;

  // sizes
  localparam int NUM_SLOTS  = 64;
  localparam int NUM_QUEUES = 2;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int LEN_W      = $clog2(NUM_SLOTS + 1);
  localparam int Q_W        = 1;
  localparam int FUNC_W     = 2;

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PULL = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_QUEUED     = 2'd2,
    ST_NOT_QUEUED = 2'd3
  } status_t;

  // one request as held in the work stage
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [Q_W-1:0]    q;
    logic [SLOT_W-1:0] slot;
    logic              cur;
  } item_t;

  // one result
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              cleared;
  } result_t;

  // one link memory write
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } link_wr_t;

  // membership word of one slot
  typedef struct packed {
    logic           queued;
    logic [Q_W-1:0] owner;
  } member_t;

  // one membership memory write
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    member_t           data;
  } member_wr_t;

  // queue heads as one vector
  typedef logic [NUM_QUEUES-1:0][SLOT_W-1:0] head_vec_t;

endpackage

// ===== hw/rtl/linked_slot_queue_engine.sv =====
// top level of the linked slot queue engine: handshakes, link memories and bypass
//
// Keeps two fifo queues of thread slots (0 waiting, 1 ready) as doubly linked
// lists. Each request on the in_ channel enqueues a slot at the tail, dequeues
// the head, or pulls a named slot from anywhere in the selected queue; each
// request gives exactly one result on the out_ channel.
// A request is taken on a rising edge with in_valid high and in_stall low; a
// result is taken with out_valid high and out_stall low. A request accepted into
// the work stage is presented on out_ when it moves on to the output register.
// Throughput: one request per cycle while out_stall is low and no clearing pass
// runs, set by the single read of each memory at acceptance and its write as the
// request completes, with a one entry bypass between back to back requests.
// When the receiver stalls, the waiting result holds in the output register
// and one more request is still accepted into the work stage; further
// requests see in_stall until the result is taken.
// Reset (rst_n low at a clock edge) empties both queues and drops any request
// in flight; a clearing pass then zeroes the slot membership memory
// with in_stall high. Links need no clearing: each is written before it is read.
module linked_slot_queue_engine
  import lsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [Q_W-1:0]    in_queue_select,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_pulled_is_current,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [LEN_W-1:0]  out_new_length,
  output logic              out_current_cleared
);

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              s1_fire;
  logic              accept;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res;
  link_wr_t          wr_head, wr_tail;
  head_vec_t         head_eff;
  logic [SLOT_W-1:0] rd_addr_t;
  logic [SLOT_W-1:0] ram_head_q, ram_tail_q;
  logic              byp_head_hit_r, byp_tail_hit_r;
  logic [SLOT_W-1:0] byp_head_data_r, byp_tail_data_r;
  logic [SLOT_W-1:0] link_head, link_tail;
  logic              clr_busy_r;
  logic [SLOT_W-1:0] clr_addr_r;
  member_wr_t        wr_member;
  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_addr;
  member_t           mem_wr_data;
  member_t           ram_member_q, member;
  logic              byp_mem_hit_r;
  member_t           byp_mem_data_r;

  // handshake control
  assign s1_fire      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = clr_busy_r || (s1_valid_r && !s1_fire);
  assign accept       = in_valid && !in_stall;
  assign s1_valid_nxt = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  // work stage request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{func: in_func, q: in_queue_select, slot: in_slot,
                     cur: in_pulled_is_current};
    end
  end

  // clearing pass over the membership memory after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + SLOT_W'(1);
      if (clr_addr_r == SLOT_W'(NUM_SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // dequeue reads the link of the head as it stands after the request ahead
  assign rd_addr_t = (in_func == FN_DEQ) ? head_eff[in_queue_select] : in_slot;

  // links toward the head
  lsq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_link_head (
    .clk     (clk),
    .wr_en   (wr_head.en),
    .wr_addr (wr_head.addr),
    .wr_data (wr_head.data),
    .rd_en   (accept),
    .rd_addr (in_slot),
    .rd_data (ram_head_q)
  );

  // links toward the tail
  lsq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_link_tail (
    .clk     (clk),
    .wr_en   (wr_tail.en),
    .wr_addr (wr_tail.addr),
    .wr_data (wr_tail.data),
    .rd_en   (accept),
    .rd_addr (rd_addr_t),
    .rd_data (ram_tail_q)
  );

  // membership write: clearing pass first, then list updates
  assign mem_wr_en   = clr_busy_r || wr_member.en;
  assign mem_wr_addr = clr_busy_r ? clr_addr_r : wr_member.addr;
  assign mem_wr_data = clr_busy_r ? member_t'('0) : wr_member.data;

  // queued bit and owner queue per slot
  lsq_ram #(.WIDTH($bits(member_t)), .DEPTH(NUM_SLOTS)) u_member (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (in_slot),
    .rd_data (ram_member_q)
  );

  // bypass a word written at the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_head_hit_r <= 1'b0;
      byp_tail_hit_r <= 1'b0;
      byp_mem_hit_r  <= 1'b0;
    end else if (accept) begin
      byp_head_hit_r <= wr_head.en && (wr_head.addr == in_slot);
      byp_tail_hit_r <= wr_tail.en && (wr_tail.addr == rd_addr_t);
      byp_mem_hit_r  <= wr_member.en && (wr_member.addr == in_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_head_data_r <= wr_head.data;
      byp_tail_data_r <= wr_tail.data;
      byp_mem_data_r  <= wr_member.data;
    end
  end

  assign link_head = byp_head_hit_r ? byp_head_data_r : ram_head_q;
  assign link_tail = byp_tail_hit_r ? byp_tail_data_r : ram_tail_q;
  assign member    = byp_mem_hit_r ? byp_mem_data_r : ram_member_q;

  // list update
  lsq_list_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .item      (s1_item_r),
    .link_head (link_head),
    .link_tail (link_tail),
    .member    (member),
    .res       (res),
    .wr_head   (wr_head),
    .wr_tail   (wr_tail),
    .wr_member (wr_member),
    .head_eff  (head_eff)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_slot            = out_res_r.slot;
  assign out_new_length      = out_res_r.len;
  assign out_current_cleared = out_res_r.cleared;

  // a request blocked in the work stage stays there unchanged
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_item_r))
    else $error("blocked request lost or changed");

  // outside the clearing pass, memories are written only when a request completes
  a_wr_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    wr_head.en || wr_tail.en || wr_member.en |-> s1_fire)
    else $error("memory write without a completing request");

  // a completing request always leaves a result behind
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result missing after completion");

  // no request enters while the membership memory is being cleared
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall && !s1_valid_r)
    else $error("request taken during clearing pass");

endmodule

// ===== hw/rtl/lsq_ram.sv =====
// generic single write port ram with registered read
module lsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write and read; a read at a written address returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lsq_list_ctrl.sv =====
// queue pointers, membership bits and the single pass list update
module lsq_list_ctrl
  import lsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  item_t             item,
  input  logic [SLOT_W-1:0] link_head,
  input  logic [SLOT_W-1:0] link_tail,
  input  member_t           member,
  output result_t           res,
  output link_wr_t          wr_head,
  output link_wr_t          wr_tail,
  output member_wr_t        wr_member,
  output head_vec_t         head_eff
);

  head_vec_t                                head_r, head_nxt;
  head_vec_t                                tail_r, tail_nxt;
  logic [NUM_QUEUES-1:0][LEN_W-1:0]         len_r, len_nxt;

  logic [Q_W-1:0]    q;
  logic [SLOT_W-1:0] s, h, t;
  logic [LEN_W-1:0]  l;
  logic              take;
  logic              detach;
  logic [SLOT_W-1:0] detach_slot;
  link_wr_t          wh, wt;
  member_wr_t        mw;

  assign q = item.q;
  assign s = item.slot;
  assign h = head_r[q];
  assign t = tail_r[q];
  assign l = len_r[q];

  // decode the request and build the next state
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    res         = '0;
    res.status  = ST_OK;
    wh          = '0;
    wt          = '0;
    mw          = '0;
    take        = 1'b0;
    detach      = 1'b0;
    detach_slot = s;
    case (item.func)
      FN_ENQ: begin
        if (member.queued) begin
          res.status = ST_QUEUED;
        end else begin
          if (l == '0) begin
            head_nxt[q] = s;
          end else begin
            wt = '{en: 1'b1, addr: t, data: s};
            wh = '{en: 1'b1, addr: s, data: t};
          end
          tail_nxt[q] = s;
          mw          = '{en: 1'b1, addr: s, data: '{queued: 1'b1, owner: q}};
          len_nxt[q]  = l + LEN_W'(1);
        end
      end
      FN_DEQ: begin
        if (l == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.slot = h;
          take     = 1'b1;
        end
      end
      FN_PULL: begin
        if (item.cur) begin
          res.cleared = 1'b1;
          res.slot    = s;
        end else if (!member.queued || member.owner != q) begin
          res.status = ST_NOT_QUEUED;
        end else begin
          res.slot = s;
          if (s == h) begin
            take = 1'b1;
          end else if (s == t) begin
            // pull at the tail: the neighbor toward the head becomes tail
            tail_nxt[q] = link_head;
            len_nxt[q]  = l - LEN_W'(1);
            detach      = 1'b1;
          end else begin
            // pull from the middle: splice the two neighbors together
            wt = '{en: 1'b1, addr: link_head, data: link_tail};
            wh = '{en: 1'b1, addr: link_tail, data: link_head};
            len_nxt[q] = l - LEN_W'(1);
            detach     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // remove the head of the selected queue
    if (take) begin
      if (l <= LEN_W'(1)) begin
        head_nxt[q] = '0;
        tail_nxt[q] = '0;
        len_nxt[q]  = '0;
      end else begin
        head_nxt[q] = link_tail;
        len_nxt[q]  = l - LEN_W'(1);
      end
      detach      = 1'b1;
      detach_slot = h;
    end

    // slot leaves its queue
    if (detach) begin
      mw = '{en: 1'b1, addr: detach_slot, data: member_t'('0)};
    end

    res.len = len_nxt[q];
  end

  assign wr_head   = '{en: wh.en & fire, addr: wh.addr, data: wh.data};
  assign wr_tail   = '{en: wt.en & fire, addr: wt.addr, data: wt.data};
  assign wr_member = '{en: mw.en & fire, addr: mw.addr, data: mw.data};
  assign head_eff  = fire ? head_nxt : head_r;

  // queue state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      len_r  <= '0;
    end else if (fire) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      len_r  <= len_nxt;
    end
  end

  // total of queue lengths
  function automatic logic [LEN_W+3:0] len_sum(logic [NUM_QUEUES-1:0][LEN_W-1:0] v);
    logic [LEN_W+3:0] acc;
    acc = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      acc = acc + (LEN_W+4)'(v[i]);
    end
    return acc;
  endfunction

  // queues together never hold more than every slot
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_sum(len_r) <= (LEN_W+4)'(NUM_SLOTS))
    else $error("queue lengths exceed the slot count");

  // an accepted enqueue marks the slot queued
  a_enq_sets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.func == FN_ENQ && res.status == ST_OK
      |-> wr_member.en && wr_member.data.queued)
    else $error("enqueued slot not marked queued");

  // an empty queue keeps both ends at zero
  for (genvar gi = 0; gi < NUM_QUEUES; gi++) begin : g_chk
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
      len_r[gi] == '0 |-> head_r[gi] == '0 && tail_r[gi] == '0)
      else $error("empty queue with nonzero ends");
  end

endmodule

// ===== verif/tb.sv =====
// testbench for the linked slot queue engine: directed table, random requests, model check
`timescale 1ns / 1ps

module tb;
  import lsq_pkg::*;

  // unused function code, ignored by the block
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  // null link code
  localparam logic [SLOT_W:0] LINK_NULL = (SLOT_W+1)'(NUM_SLOTS);

  localparam int RAND_ITEMS  = 750;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AFTER  = 300;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DIR_N       = 25;

  // one row of the directed table; chk selects the typed result over the model
  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [Q_W-1:0]    q;
    logic [SLOT_W-1:0] slot;
    logic              cur;
    logic              chk;
    result_t           res;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [Q_W-1:0]    in_queue_select;
  logic [SLOT_W-1:0] in_slot;
  logic              in_pulled_is_current;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [LEN_W-1:0]  out_new_length;
  logic              out_current_cleared;

  // typed expectation that goes with the request on the bus
  logic    typed_check;
  result_t typed_result;

  int errors;
  int items_sent;
  result_t pending_results[$];

  // queue model state
  logic [SLOT_W-1:0] m_head [NUM_QUEUES];
  logic [SLOT_W-1:0] m_tail [NUM_QUEUES];
  int unsigned       m_len  [NUM_QUEUES];
  logic [SLOT_W:0]   m_up   [NUM_SLOTS];
  logic [SLOT_W:0]   m_dn   [NUM_SLOTS];
  logic              m_queued [NUM_SLOTS];
  logic [Q_W-1:0]    m_owner  [NUM_SLOTS];

  dir_row_t dir_table [DIR_N] = '{
    '{FN_DEQ,    1'b0, 6'd0,  1'b0, 1'b1, '{ST_EMPTY,      6'd0,  7'd0, 1'b0}},
    '{FN_DEQ,    1'b1, 6'd0,  1'b0, 1'b1, '{ST_EMPTY,      6'd0,  7'd0, 1'b0}},
    '{FN_PULL,   1'b0, 6'd5,  1'b0, 1'b1, '{ST_NOT_QUEUED, 6'd0,  7'd0, 1'b0}},
    '{FN_PULL,   1'b1, 6'd63, 1'b1, 1'b1, '{ST_OK,         6'd63, 7'd0, 1'b1}},
    '{FN_ENQ,    1'b0, 6'd0,  1'b1, 1'b1, '{ST_OK,         6'd0,  7'd1, 1'b0}},
    '{FN_ENQ,    1'b0, 6'd63, 1'b0, 1'b1, '{ST_OK,         6'd0,  7'd2, 1'b0}},
    '{FN_ENQ,    1'b0, 6'd0,  1'b0, 1'b1, '{ST_QUEUED,     6'd0,  7'd2, 1'b0}},
    '{FN_ENQ,    1'b1, 6'd63, 1'b0, 1'b1, '{ST_QUEUED,     6'd0,  7'd0, 1'b0}},
    '{FN_ENQ,    1'b0, 6'd21, 1'b0, 1'b1, '{ST_OK,         6'd0,  7'd3, 1'b0}},
    '{FN_ENQ,    1'b0, 6'd42, 1'b0, 1'b1, '{ST_OK,         6'd0,  7'd4, 1'b0}},
    '{FN_PULL,   1'b1, 6'd21, 1'b0, 1'b1, '{ST_NOT_QUEUED, 6'd0,  7'd0, 1'b0}},
    '{FN_PULL,   1'b0, 6'd63, 1'b0, 1'b1, '{ST_OK,         6'd63, 7'd3, 1'b0}},
    '{FN_PULL,   1'b0, 6'd42, 1'b0, 1'b1, '{ST_OK,         6'd42, 7'd2, 1'b0}},
    '{FN_PULL,   1'b0, 6'd0,  1'b0, 1'b1, '{ST_OK,         6'd0,  7'd1, 1'b0}},
    '{FN_UNUSED, 1'b0, 6'd63, 1'b1, 1'b1, '{ST_OK,         6'd0,  7'd1, 1'b0}},
    '{FN_ENQ,    1'b1, 6'd42, 1'b0, 1'b1, '{ST_OK,         6'd0,  7'd1, 1'b0}},
    '{FN_ENQ,    1'b1, 6'd0,  1'b0, 1'b1, '{ST_OK,         6'd0,  7'd2, 1'b0}},
    '{FN_DEQ,    1'b1, 6'd0,  1'b0, 1'b1, '{ST_OK,         6'd42, 7'd1, 1'b0}},
    '{FN_DEQ,    1'b0, 6'd0,  1'b0, 1'b1, '{ST_OK,         6'd21, 7'd0, 1'b0}},
    '{FN_PULL,   1'b1, 6'd0,  1'b0, 1'b1, '{ST_OK,         6'd0,  7'd0, 1'b0}},
    '{FN_DEQ,    1'b1, 6'd0,  1'b0, 1'b1, '{ST_EMPTY,      6'd0,  7'd0, 1'b0}},
    '{FN_ENQ,    1'b0, 6'd63, 1'b0, 1'b1, '{ST_OK,         6'd0,  7'd1, 1'b0}},
    '{FN_PULL,   1'b0, 6'd63, 1'b1, 1'b1, '{ST_OK,         6'd63, 7'd1, 1'b1}},
    '{FN_ENQ,    1'b0, 6'd42, 1'b0, 1'b0, '{ST_OK,         6'd0,  7'd0, 1'b0}},
    '{FN_DEQ,    1'b0, 6'd0,  1'b0, 1'b0, '{ST_OK,         6'd0,  7'd0, 1'b0}}
  };

  linked_slot_queue_engine DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_queue_select      (in_queue_select),
    .in_slot              (in_slot),
    .in_pulled_is_current (in_pulled_is_current),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_new_length       (out_new_length),
    .out_current_cleared  (out_current_cleared)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one mismatch line and count
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // unlink a slot from every queue
  function automatic void detach_slot(input logic [SLOT_W-1:0] s);
    m_up[s]     = LINK_NULL;
    m_dn[s]     = LINK_NULL;
    m_queued[s] = 1'b0;
    m_owner[s]  = '0;
  endfunction

  // remove the head of a non-empty queue
  function automatic logic [SLOT_W-1:0] take_head(input int q);
    logic [SLOT_W-1:0] h;
    logic [SLOT_W:0]   nh;
    h = m_head[q];
    if (m_len[q] <= 1) begin
      m_head[q] = '0;
      m_tail[q] = '0;
      m_len[q]  = 0;
    end else begin
      nh = m_dn[h];
      if (nh != LINK_NULL) begin
        m_head[q] = nh[SLOT_W-1:0];
        m_up[nh[SLOT_W-1:0]] = LINK_NULL;
      end
      m_len[q]--;
    end
    detach_slot(h);
    return h;
  endfunction

  // apply one request to the queue model and return its result
  function automatic result_t queue_op_result(input logic [FUNC_W-1:0] fn,
                                              input logic [Q_W-1:0] qsel,
                                              input logic [SLOT_W-1:0] s,
                                              input logic cur);
    result_t         r;
    logic [SLOT_W:0] th;
    logic [SLOT_W:0] tt;
    int              q;
    q = int'(qsel) % NUM_QUEUES;
    r = '0;
    r.status = ST_OK;
    case (fn)
      FN_ENQ: begin
        if (m_queued[s]) begin
          r.status = ST_QUEUED;
        end else begin
          m_up[s] = LINK_NULL;
          m_dn[s] = LINK_NULL;
          if (m_len[q] == 0) begin
            m_head[q] = s;
          end else begin
            m_dn[m_tail[q]] = {1'b0, s};
            m_up[s] = {1'b0, m_tail[q]};
          end
          m_tail[q]   = s;
          m_queued[s] = 1'b1;
          m_owner[s]  = qsel;
          m_len[q]++;
        end
      end
      FN_DEQ: begin
        if (m_len[q] == 0) r.status = ST_EMPTY;
        else r.slot = take_head(q);
      end
      FN_PULL: begin
        if (cur) begin
          // running thread: only cleared
          r.cleared = 1'b1;
          r.slot    = s;
        end else if (!m_queued[s] || m_owner[s] != qsel) begin
          r.status = ST_NOT_QUEUED;
        end else begin
          th = m_up[s];
          tt = m_dn[s];
          r.slot = s;
          if (th == LINK_NULL) begin
            void'(take_head(q));
          end else if (tt == LINK_NULL) begin
            m_tail[q] = th[SLOT_W-1:0];
            m_dn[th[SLOT_W-1:0]] = LINK_NULL;
            m_len[q]--;
            detach_slot(s);
          end else begin
            m_dn[th[SLOT_W-1:0]] = tt;
            m_up[tt[SLOT_W-1:0]] = th;
            m_len[q]--;
            detach_slot(s);
          end
        end
      end
      default: ;
    endcase
    r.len = LEN_W'(m_len[q]);
    return r;
  endfunction

  // offer one request from a falling edge and hold it until taken
  task automatic offer(input logic [FUNC_W-1:0] fn, input logic [Q_W-1:0] qsel,
                       input logic [SLOT_W-1:0] s, input logic cur,
                       input logic chk, input result_t res);
    in_func              <= fn;
    in_queue_select      <= qsel;
    in_slot              <= s;
    in_pulled_is_current <= cur;
    typed_check          <= chk;
    typed_result         <= res;
    in_valid             <= 1'b1;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // sender gap
  task automatic pause(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // check results, then model each accepted request
  always @(posedge clk) begin
    result_t want;
    result_t model_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending, slot", out_slot, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_slot !== want.slot)
            report_mismatch("out_slot", out_slot, want.slot);
          if (out_new_length !== want.len)
            report_mismatch("new_length", out_new_length, want.len);
          if (out_current_cleared !== want.cleared)
            report_mismatch("current_cleared", out_current_cleared, want.cleared);
        end
      end
      if (in_valid && !in_stall) begin
        model_res = queue_op_result(in_func, in_queue_select, in_slot,
                                    in_pulled_is_current);
        pending_results.push_back(typed_check ? typed_result : model_res);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle = 0;
      else idle++;
    end
    $display("linked_slot_queue_engine: mismatch");
    $finish;
  end

  // receiver stall patterns, with one long hold-off to back up the block
  initial begin : receiver
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // reset, directed table, random requests, drain
  initial begin : sender
    int n;
    int burst;
    int roll;
    int k;
    int enq_weight;
    logic [FUNC_W-1:0] fn;
    logic [Q_W-1:0]    qsel;
    logic [SLOT_W-1:0] sl;
    logic              cur;

    errors               = 0;
    items_sent           = 0;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_func              = FN_ENQ;
    in_queue_select      = '0;
    in_slot              = '0;
    in_pulled_is_current = 1'b0;
    typed_check          = 1'b0;
    typed_result         = '0;
    for (k = 0; k < NUM_QUEUES; k++) begin
      m_head[k] = '0;
      m_tail[k] = '0;
      m_len[k]  = 0;
    end
    for (k = 0; k < NUM_SLOTS; k++) detach_slot(SLOT_W'(k));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_table[i]) begin
      offer(dir_table[i].fn, dir_table[i].q, dir_table[i].slot, dir_table[i].cur,
            dir_table[i].chk, dir_table[i].res);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 4));
    end

    // random bursts of mostly well-formed requests
    n = 0;
    while (n < RAND_ITEMS) begin
      burst      = $urandom_range(1, 24);
      enq_weight = $urandom_range(25, 55);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        qsel = Q_W'($urandom_range(0, 1));
        sl   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        cur  = 1'($urandom_range(0, 1));
        if (roll < enq_weight) begin
          // enqueue a free slot when there is one
          fn = FN_ENQ;
          for (k = 0; k < NUM_SLOTS && m_queued[sl]; k++) sl = sl + 1'b1;
        end else if (roll < enq_weight + 20) begin
          fn = FN_DEQ;
        end else if (roll < 92) begin
          // pull a member from a random position of the selected queue
          fn  = FN_PULL;
          cur = 1'b0;
          if (m_len[qsel] != 0) begin
            sl = m_head[qsel];
            repeat ($urandom_range(0, m_len[qsel] - 1)) sl = m_dn[sl][SLOT_W-1:0];
          end
        end else if (roll < 95) begin
          // running thread or stray slot
          fn = FN_PULL;
        end else begin
          // noise, unused code included
          fn = FUNC_W'($urandom_range(0, 3));
        end
        offer(fn, qsel, sl, cur, 1'b0, '0);
        if (fn != FN_UNUSED) n++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("linked_slot_queue_engine: match");
    end else begin
      $display("linked_slot_queue_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lsq_pkg.sv
hw/rtl/lsq_ram.sv
hw/rtl/lsq_list_ctrl.sv
hw/rtl/linked_slot_queue_engine.sv
verif/tb.sv
